FILE: design/cltkh_pkg.sv
// ----------------------------------------------------------------------------
// cltkh_pkg
// shared sizes, entry type, codes and the controller/datapath interface
// ----------------------------------------------------------------------------
package cltkh_pkg;

  localparam int MAX_ENTRIES  = 64;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;

  localparam int SLOTS  = MAX_ENTRIES + 1;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int IDX_W  = ADDR_W + 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CAP_W  = 7;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EMPTY_ERR = 1'b1;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload;
    logic [KEY_BITS-1:0]     key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller -> datapath strobes
  typedef struct packed {
    logic accept;     // latch error flag for the new beat
    logic set_err;    // remove on an empty heap
    logic start_ins;  // new entry into the hole at the tail
    logic up_rd;      // read the parent of the hole
    logic up_move;    // parent drops into the hole
    logic place;      // moving entry lands in the hole
    logic pop_rd;     // read the last slot, shrink the count
    logic pop_ld;     // last slot becomes the moving entry, hole at root
    logic dn_rdl;     // read left child
    logic dn_rdr;     // check left child, read right child
    logic dn_move;    // smaller child rises into the hole
    logic load_out;   // capture the result beat
  } cmd_t;

  // datapath -> controller flags
  typedef struct packed {
    logic empty;
    logic cap_zero;
    logic pos_zero;
    logic up_lt;
    logic over_cap;
    logic l_valid;
    logic dn_take;
  } sts_t;

endpackage

FILE: design/cltkh_ram.sv
// ----------------------------------------------------------------------------
// cltkh_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cltkh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

FILE: design/cltkh_ctrl.sv
// ----------------------------------------------------------------------------
// cltkh_ctrl
// sequencer for insert, sift up, pop and sift down; owns the beat handshakes
// ----------------------------------------------------------------------------
module cltkh_ctrl
  import cltkh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic in_func,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_UP_RD  = 9'b000000010,
    S_UP_CMP = 9'b000000100,
    S_POP_RD = 9'b000001000,
    S_POP_LD = 9'b000010000,
    S_DN_RDL = 9'b000100000,
    S_DN_RDR = 9'b001000000,
    S_DN_CMP = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  // no beat is taken while reset is held
  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.accept = 1'b1;
          if (in_func == FUNC_INSERT) begin
            if (sts.cap_zero) begin
              state_nxt = S_FIN;
            end else begin
              cmd.start_ins = 1'b1;
              state_nxt     = S_UP_RD;
            end
          end else begin
            if (sts.empty) begin
              cmd.set_err = 1'b1;
              state_nxt   = S_FIN;
            end else begin
              cmd.pop_rd = 1'b1;
              state_nxt  = S_POP_LD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (sts.pos_zero) begin
          cmd.place = 1'b1;
          state_nxt = sts.over_cap ? S_POP_RD : S_FIN;
        end else begin
          cmd.up_rd = 1'b1;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_lt) begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP_RD;
        end else begin
          cmd.place = 1'b1;
          state_nxt = sts.over_cap ? S_POP_RD : S_FIN;
        end
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = S_POP_LD;
      end
      S_POP_LD: begin
        cmd.pop_ld = 1'b1;
        state_nxt  = sts.empty ? S_FIN : S_DN_RDL;
      end
      S_DN_RDL: begin
        if (sts.l_valid) begin
          cmd.dn_rdl = 1'b1;
          state_nxt  = S_DN_RDR;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_DN_RDR: begin
        cmd.dn_rdr = 1'b1;
        state_nxt  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.dn_take) begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DN_RDL;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a remove on an empty heap goes straight to the result
  a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func == FUNC_REMOVE && sts.empty) |=> (state_r == S_FIN))
    else $error("empty remove did not go to result");

endmodule

FILE: design/cltkh_dp.sv
// ----------------------------------------------------------------------------
// cltkh_dp
// heap ram, hole position, moving entry, count, capacity and result register
// ----------------------------------------------------------------------------
module cltkh_dp
  import cltkh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [63:0]      in_tdata,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  output logic [71:0]      out_tdata,
  output logic [0:0]       out_tuser
);

  logic [CNT_W-1:0]  cnt_r;
  logic [CAP_W-1:0]  cap_r;
  logic [ADDR_W-1:0] pos_r;
  entry_t            cur_r, left_r, root_r;
  logic              take_left_r;
  logic              err_r;
  logic [71:0]       out_tdata_r;
  logic              out_err_r;

  logic [CNT_W-1:0]  cap_eff;
  logic [ADDR_W-1:0] parent;
  logic [IDX_W-1:0]  l_idx, r_idx;
  logic              r_valid, right_lt;
  logic [KEY_BITS-1:0] best_key;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  entry_t            wr_data, rd_data, in_entry;

  assign in_entry.key     = in_tdata[KEY_BITS-1:0];
  assign in_entry.payload = in_tdata[32 +: PAYLOAD_BITS];

  always_comb begin
    if (32'(cap_r) > 32'(MAX_ENTRIES)) begin
      cap_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  assign parent   = ADDR_W'((pos_r - ADDR_W'(1)) >> 1);
  assign l_idx    = {pos_r, 1'b1};
  assign r_idx    = l_idx + IDX_W'(1);
  assign r_valid  = 32'(r_idx) < 32'(cnt_r);
  assign best_key = take_left_r ? left_r.key : cur_r.key;
  assign right_lt = r_valid && (rd_data.key < best_key);

  assign sts.empty    = (cnt_r == '0);
  assign sts.cap_zero = (cap_eff == '0);
  assign sts.pos_zero = (pos_r == '0);
  assign sts.up_lt    = cur_r.key < rd_data.key;
  assign sts.over_cap = cnt_r > cap_eff;
  assign sts.l_valid  = 32'(l_idx) < 32'(cnt_r);
  assign sts.dn_take  = take_left_r || right_lt;

  // one ram read per step; read data is used the following cycle
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    priority if (cmd.up_rd) begin
      rd_en   = 1'b1;
      rd_addr = parent;
    end else if (cmd.pop_rd) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(cnt_r - CNT_W'(1));
    end else if (cmd.dn_rdl) begin
      rd_en   = 1'b1;
      rd_addr = l_idx[ADDR_W-1:0];
    end else if (cmd.dn_rdr) begin
      rd_en   = r_valid;
      rd_addr = r_idx[ADDR_W-1:0];
    end else begin
      rd_en   = 1'b0;
    end
  end

  // hole method: only the entry that fills the hole is written
  always_comb begin
    wr_en   = cmd.place || cmd.up_move || cmd.dn_move;
    wr_addr = pos_r;
    priority if (cmd.up_move) begin
      wr_data = rd_data;
    end else if (cmd.dn_move) begin
      wr_data = right_lt ? rd_data : left_r;
    end else begin
      wr_data = cur_r;
    end
  end

  cltkh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cap_r <= CAP_W'(MAX_ENTRIES);
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.start_ins) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.pop_rd) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      err_r <= cmd.set_err;
    end
    if (cmd.start_ins) begin
      cur_r <= in_entry;
      pos_r <= cnt_r[ADDR_W-1:0];
    end else if (cmd.pop_ld) begin
      cur_r <= rd_data;
      pos_r <= '0;
    end else if (cmd.up_move) begin
      pos_r <= parent;
    end else if (cmd.dn_move) begin
      pos_r <= right_lt ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];
    end
    if (cmd.dn_rdr) begin
      left_r      <= rd_data;
      take_left_r <= rd_data.key < cur_r.key;
    end
    if (wr_en && wr_addr == '0) begin
      root_r <= wr_data;
    end
    if (cmd.load_out) begin
      out_tdata_r[31:0]  <= (cnt_r != '0) ? 32'(root_r.key) : 32'd0;
      out_tdata_r[63:32] <= (cnt_r != '0) ? 32'(root_r.payload) : 32'd0;
      out_tdata_r[70:64] <= 7'(cnt_r);
      out_tdata_r[71]    <= (cnt_r == '0);
      out_err_r          <= err_r ? STATUS_EMPTY_ERR : STATUS_OK;
    end
  end

  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_err_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= SLOTS)
    else $error("fill count beyond slot count");

  a_cnt_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> 32'(cnt_r) <= MAX_ENTRIES)
    else $error("count above capacity at result");

  a_root_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.place && pos_r == '0) |=> (root_r == $past(cur_r)))
    else $error("root copy not updated");

endmodule

FILE: design/capacity_limited_top_k_heap.sv
// ----------------------------------------------------------------------------
// capacity_limited_top_k_heap
// bounded min-heap that keeps the largest keys seen, up to a set capacity
// ----------------------------------------------------------------------------
// in_*  : one beat per operation; in_tuser[0] = 0 insert, 1 remove minimum
// out_* : one beat per operation with root key/payload, count, empty flag and
//         in out_tuser[0] the error flag (remove on an empty heap)
// cfg_* : capacity, 0 ignores inserts, above 64 acts as 64; the user raises
//   cfg_wr_en only while no operation is in flight; the block does not check
// flow: one operation at a time, in_tready high only while the sequencer
//   idles; one ram read per step, so a sift up level reads the parent and
//   compares, a sift down level reads the left child, then the right child,
//   then compares; insert with eviction sifts up, then pops and sifts down;
//   the beat shows on out_* the cycle after the result load
// reset: synchronous, active low; heap empty, capacity back to 64, no beat
//   taken while held; ram contents are never read before written
// stall: a finished result waits in the output register while out_tready is
//   low and the next beat is already taken; the sequencer only waits when a
//   second result is ready before the first one leaves
// ----------------------------------------------------------------------------
module capacity_limited_top_k_heap
  import cltkh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,    // entry_key[31:0], entry_payload[63:32]
  input  logic [0:0]       in_tuser,    // func[0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [71:0]      out_tdata,   // min_key[31:0], min_payload[63:32],
                                        // entry_count[70:64], is_empty[71]
  output logic [0:0]       out_tuser,   // status[0]
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data  // capacity_limit
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: decides each step from the datapath flags
  cltkh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // heap storage, compares and result register
  cltkh_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bounded top-k min-heap: a shadow heap predicts
// root, count, empty flag and error flag for every accepted operation beat,
// both stream sides idle and stall at random, capacity swept between phases
// ----------------------------------------------------------------------------
module tb
  import cltkh_pkg::*;
();

  // idle time after the last result before a capacity write or the end
  localparam int SETTLE_CYCLES = 40;
  // cycles with no beat on either side before the run is declared hung
  localparam int STUCK_LIMIT   = 2000;
  // operation beats to send in total, directed part included
  localparam int OPS_TARGET    = 1550;
  localparam int MAX_IDLE      = 18;

  // expected result of one operation, same field order as the result beat
  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [CNT_W-1:0]        count;
    logic                    empty;
    logic                    status;
  } heap_view_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [63:0]      in_tdata;    // entry_key[31:0], entry_payload[63:32]
  logic [0:0]       in_tuser;    // func[0]
  logic             out_tvalid;
  logic             out_tready;
  logic [71:0]      out_tdata;   // min_key[31:0], min_payload[63:32],
                                 // entry_count[70:64], is_empty[71]
  logic [0:0]       out_tuser;   // status[0]
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data; // capacity_limit

  capacity_limited_top_k_heap uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // shadow heap: slot array, fill level and the capacity register as written
  logic [KEY_BITS-1:0]     shadow_keys [SLOTS];
  logic [PAYLOAD_BITS-1:0] shadow_pay  [SLOTS];
  int                      shadow_fill;
  logic [CAP_W-1:0]        shadow_cap;

  heap_view_t pending_views[$];  // predicted results still to come out
  int         mismatch_count;
  int         ops_sent;          // operation beats accepted so far
  bit         tx_calm;           // sender runs back to back while set
  bit         rx_calm;           // receiver never stalls while set

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow heap
  // ---------------------------------------------------------------------------
  function automatic void swap_slots(input int a, input int b);
    logic [KEY_BITS-1:0]     k;
    logic [PAYLOAD_BITS-1:0] p;
    k = shadow_keys[a];
    p = shadow_pay[a];
    shadow_keys[a] = shadow_keys[b];
    shadow_pay[a]  = shadow_pay[b];
    shadow_keys[b] = k;
    shadow_pay[b]  = p;
  endfunction

  // new entry climbs while strictly below its parent
  function automatic void bubble_up(input int pos);
    int up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!(shadow_keys[pos] < shadow_keys[up])) break;
      swap_slots(pos, up);
      pos = up;
    end
  endfunction

  // last entry to the root, then down; left child wins ties with the right,
  // a move happens only on strictly less
  function automatic void evict_root();
    int pos;
    int lo;
    int l;
    int r;
    shadow_fill--;
    shadow_keys[0] = shadow_keys[shadow_fill];
    shadow_pay[0]  = shadow_pay[shadow_fill];
    pos = 0;
    while (pos < shadow_fill) begin
      lo = pos;
      l  = 2 * pos + 1;
      r  = 2 * pos + 2;
      if (l < shadow_fill && shadow_keys[l] < shadow_keys[lo]) lo = l;
      if (r < shadow_fill && shadow_keys[r] < shadow_keys[lo]) lo = r;
      if (lo == pos) break;
      swap_slots(pos, lo);
      pos = lo;
    end
  endfunction

  function automatic heap_view_t predict_heap_op(input logic op,
                                                 input logic [KEY_BITS-1:0] key,
                                                 input logic [PAYLOAD_BITS-1:0] payload);
    int         room;
    heap_view_t view;
    room = (shadow_cap > MAX_ENTRIES) ? MAX_ENTRIES : int'(shadow_cap);
    view.status = STATUS_OK;
    if (op == FUNC_INSERT) begin
      // zero capacity: insert has no effect at all
      if (room != 0) begin
        shadow_keys[shadow_fill] = key;
        shadow_pay[shadow_fill]  = payload;
        shadow_fill++;
        bubble_up(shadow_fill - 1);
        if (shadow_fill > room) evict_root();
      end
    end else if (shadow_fill == 0) begin
      view.status = STATUS_EMPTY_ERR;
    end else begin
      evict_root();
    end
    view.key     = (shadow_fill > 0) ? shadow_keys[0] : '0;
    view.payload = (shadow_fill > 0) ? shadow_pay[0]  : '0;
    view.count   = CNT_W'(shadow_fill);
    view.empty   = (shadow_fill == 0);
    return view;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // one operation beat: random gap, then hold until taken
  task automatic push_op(input logic op, input logic [KEY_BITS-1:0] key,
                         input logic [PAYLOAD_BITS-1:0] payload);
    int gap;
    if ($urandom_range(0, 47) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {payload, key};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    pending_views.insert(pending_views.size(), predict_heap_op(op, key, payload));
    ops_sent++;
  endtask

  // stop sending and let every result drain before touching the register
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    shadow_cap = value;
  endtask

  // mix of tie-heavy small keys, the two extremes and full-range keys
  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return KEY_BITS'($urandom_range(0, 15));
      1: return ($urandom_range(0, 1) == 1) ? '1 : '0;
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // empty heap error, field extremes, drain back to empty
  task automatic test_extremes();
    push_op(FUNC_REMOVE, '0, '0);                    // remove on an empty heap
    push_op(FUNC_INSERT, '1, '1);
    push_op(FUNC_INSERT, '0, '0);
    push_op(FUNC_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    push_op(FUNC_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    repeat (4) push_op(FUNC_REMOVE, '1, '1);
    push_op(FUNC_REMOVE, '0, '0);                    // empty again
  endtask

  // equal keys: payload order shows which way ties were broken
  task automatic test_equal_keys();
    int i;
    for (i = 1; i <= 5; i++) push_op(FUNC_INSERT, 32'd7, PAYLOAD_BITS'(i));
    push_op(FUNC_INSERT, 32'd6, 32'd60);
    repeat (3) push_op(FUNC_REMOVE, '0, '0);
  endtask

  // zero capacity, small capacity, capacity dropped below the count
  task automatic test_capacity_edges();
    write_capacity(7'd0);
    push_op(FUNC_INSERT, 32'd100, 32'd1);            // ignored
    push_op(FUNC_REMOVE, '0, '0);                    // removes still work
    write_capacity(7'd2);
    push_op(FUNC_INSERT, 32'd50, 32'd2);
    push_op(FUNC_INSERT, 32'd10, 32'd3);             // evicts the last key 7 entry
    push_op(FUNC_INSERT, 32'd90, 32'd4);
    write_capacity(7'd1);                            // below current count
    push_op(FUNC_INSERT, 32'd70, 32'd5);
    push_op(FUNC_REMOVE, '0, '0);
  endtask

  // phases of random operations, each under its own capacity; the heap is
  // not drained in between so lowered capacities meet fuller heaps
  task automatic test_random_phases();
    int               phase;
    int               len;
    int               ins_pct;
    int               n;
    logic [CAP_W-1:0] cap;
    logic             op;
    phase = 0;
    while (ops_sent < OPS_TARGET) begin
      case (phase)
        0:       cap = 7'd127;                       // above the array size
        1:       cap = 7'd0;
        2:       cap = 7'd64;
        3:       cap = 7'd1;
        default: cap = ($urandom_range(0, 2) == 0) ? CAP_W'($urandom_range(65, 127))
                                                   : CAP_W'($urandom_range(0, 64));
      endcase
      write_capacity(cap);
      case ($urandom_range(0, 2))
        0:       ins_pct = 80;                       // fill up and evict
        1:       ins_pct = 55;
        default: ins_pct = 30;                       // drain into empty removes
      endcase
      len = (cap == 0) ? 16 : $urandom_range(60, 160);
      if (phase == 0 || phase == 2) begin
        ins_pct = 80;
        len     = 200;
      end
      // last phase stops at the target
      if (len > OPS_TARGET - ops_sent) len = OPS_TARGET - ops_sent;
      for (n = 0; n < len; n++) begin
        op = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
        push_op(op, pick_key(), PAYLOAD_BITS'($urandom));
      end
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %h expected %h", $time, field, got, want);
  endtask

  // receiver stalls a random number of cycles before each beat unless rx_calm is set
  initial begin
    int stall;
    out_tready <= 1'b0;
    forever begin
      if ($urandom_range(0, 47) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // each result beat against the oldest prediction
  always @(posedge clk) begin
    heap_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_views.size() == 0) begin
        report_mismatch("result beat with none pending", out_tdata[31:0], '0);
      end else begin
        want = pending_views.pop_front();
        if (out_tdata[31:0] !== want.key)
          report_mismatch("min_key", out_tdata[31:0], want.key);
        if (out_tdata[63:32] !== want.payload)
          report_mismatch("min_payload", out_tdata[63:32], want.payload);
        if (out_tdata[70:64] !== want.count)
          report_mismatch("entry_count", 32'(out_tdata[70:64]), 32'(want.count));
        if (out_tdata[71] !== want.empty)
          report_mismatch("is_empty", 32'(out_tdata[71]), 32'(want.empty));
        if (out_tuser[0] !== want.status)
          report_mismatch("status", 32'(out_tuser[0]), 32'(want.status));
      end
    end
  end

  // watchdog: too long without a beat on either side means a hang
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck = 0;
      else stuck++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    mismatch_count = 0;
    ops_sent       = 0;
    tx_calm        = 1'b0;
    rx_calm        = 1'b0;
    shadow_fill    = 0;
    shadow_cap     = 7'd64;  // capacity after reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_equal_keys();
    test_capacity_edges();
    test_random_phases();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: capacity_limited_top_k_heap.f
design/cltkh_pkg.sv
design/cltkh_ram.sv
design/cltkh_ctrl.sv
design/cltkh_dp.sv
design/capacity_limited_top_k_heap.sv
tb/tb.sv
